@@ design/tlbpt_pkg.sv @@
// Shared constants and control types for the TLB page translator.
`default_nettype none

package tlbpt_pkg;

   // Parameter defaults
   localparam int TLB_ENTRIES_DEF = 16;
   localparam int FRAME_COUNT_DEF = 128;
   localparam int STAMP_BITS_DEF  = 32;

   // Fixed field widths
   localparam int ADDR_W      = 16;
   localparam int PAGE_W      = 8;
   localparam int OFFSET_W    = 8;
   localparam int PADDR_W     = 15;
   localparam int FRAME_OUT_W = 7;
   localparam int SLOT_OUT_W  = 4;

   // Replacement policy codes
   localparam logic POLICY_FIFO = 1'b0;
   localparam logic POLICY_LRU  = 1'b1;

   // Sequencer commands to the frame table
   typedef struct packed {
      logic rd_en;       // read entry at rd_idx
      logic scan_start;  // this read opens a scan: restart the LRU minimum
      logic wr_en;       // write back entry at wr_idx
      logic set_page;    // write back the new page and mark the frame valid
      logic set_stamp;   // write back the new stamp and mark it valid
   } ft_ctl_type;

   // Frame table status back to the sequencer
   typedef struct packed {
      logic rd_done;     // read data of the last issued read is present
      logic page_hit;    // that entry is valid and holds the current page
   } ft_sts_type;

endpackage

`default_nettype wire

@@ design/tlbpt_frame_table.sv @@
// Inverted frame table: page and use stamp memory, valid bits, LRU minimum tracker.
`default_nettype none

module tlbpt_frame_table
   import tlbpt_pkg::*;
#(
   parameter int FRAME_COUNT = FRAME_COUNT_DEF,
   parameter int STAMP_BITS  = STAMP_BITS_DEF,
   localparam int FIW        = $clog2(FRAME_COUNT)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ft_ctl_type            ctl,
   input  wire logic [FIW-1:0]        rd_idx,
   input  wire logic [FIW-1:0]        wr_idx,
   input  wire logic [PAGE_W-1:0]     page,
   input  wire logic [STAMP_BITS-1:0] stamp_in,
   output ft_sts_type                 sts,
   output logic [FIW-1:0]             lru_idx
);

   localparam int WORD_W = PAGE_W + STAMP_BITS;

   // One word per frame: {page, stamp}
   logic [WORD_W-1:0]     frame_mem [FRAME_COUNT];
   logic [WORD_W-1:0]     rd_data_ff;
   logic                  rd_pend_ff;
   logic                  rd_first_ff;
   logic [FIW-1:0]        rd_idx_ff;
   logic [FRAME_COUNT-1:0] frame_valid_ff;
   logic [FRAME_COUNT-1:0] stamp_valid_ff;
   logic [STAMP_BITS-1:0] best_stamp_ff;
   logic [FIW-1:0]        best_idx_ff;

   logic [PAGE_W-1:0]     rd_page;
   logic [STAMP_BITS-1:0] rd_stamp;
   logic [STAMP_BITS-1:0] stamp_eff;
   logic [PAGE_W-1:0]     wb_page;
   logic [STAMP_BITS-1:0] wb_stamp;

   assign rd_page  = rd_data_ff[WORD_W-1:STAMP_BITS];
   assign rd_stamp = rd_data_ff[STAMP_BITS-1:0];

   // A stamp never written reads as zero
   assign stamp_eff = stamp_valid_ff[rd_idx_ff] ? rd_stamp : '0;

   // Write-back merges new fields with the entry read just before
   assign wb_page  = ctl.set_page  ? page     : rd_page;
   assign wb_stamp = ctl.set_stamp ? stamp_in : rd_stamp;

   // Memory port: registered read, single write
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= frame_mem[rd_idx];
         rd_idx_ff  <= rd_idx;
      end
      if (ctl.wr_en) begin
         frame_mem[wr_idx] <= {wb_page, wb_stamp};
      end
   end

   // Read tracking and valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff     <= 1'b0;
         rd_first_ff    <= 1'b0;
         frame_valid_ff <= '0;
         stamp_valid_ff <= '0;
      end else begin
         rd_pend_ff  <= ctl.rd_en;
         rd_first_ff <= ctl.rd_en & ctl.scan_start;
         if (ctl.wr_en && ctl.set_page) begin
            frame_valid_ff[wr_idx] <= 1'b1;
         end
         if (ctl.wr_en && ctl.set_stamp) begin
            stamp_valid_ff[wr_idx] <= 1'b1;
         end
      end
   end

   // Running minimum over the scan; strict compare keeps the lowest index on ties
   always_ff @(posedge clock) begin
      if (rd_pend_ff && (rd_first_ff || (stamp_eff < best_stamp_ff))) begin
         best_stamp_ff <= stamp_eff;
         best_idx_ff   <= rd_idx_ff;
      end
   end

   assign sts.rd_done  = rd_pend_ff;
   assign sts.page_hit = rd_pend_ff && frame_valid_ff[rd_idx_ff] && (rd_page == page);
   assign lru_idx      = best_idx_ff;

endmodule

`default_nettype wire

@@ design/tlb_page_translator_fifo_lru.sv @@
// Top level: TLB memory, translation sequencer, frame table and result register.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-------------------------------------------
//  req      | in        | req_valid/req_stall | req_logical_address
//  rsp      | out       | rsp_valid/rsp_stall | physical_address, frame_number, tlb_hit,
//           |           |                     | page_fault, tlb_slot
//  csr      | in        | csr_valid/csr_ready | csr_replacement_policy (0 FIFO, 1 LRU)
//
//  One address at a time. A TLB hit sweeps the TLB up to the matching entry; a miss sweeps
//  the whole TLB, then the frame table up to a page hit or its last entry. The TLB and frame
//  table are swept one entry per cycle through their registered read ports, then one
//  read-modify-write.
//  Reset is synchronous and clears valid bits, pointers and the stamp counter at once.
//  A finished result sits in the output register; the next address is taken while it
//  waits, and the block holds in its final step only if that register is full and stalled.
`default_nettype none

module tlb_page_translator_fifo_lru
   import tlbpt_pkg::*;
#(
   parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
   parameter int FRAME_COUNT = FRAME_COUNT_DEF,
   parameter int STAMP_BITS  = STAMP_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // address requests
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [ADDR_W-1:0]      req_logical_address,
   // translation results
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [PADDR_W-1:0]          rsp_physical_address,
   output logic [FRAME_OUT_W-1:0]      rsp_frame_number,
   output logic                        rsp_tlb_hit,
   output logic                        rsp_page_fault,
   output logic [SLOT_OUT_W-1:0]       rsp_tlb_slot,
   // policy register write
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic                   csr_replacement_policy
);

   localparam int TIW   = $clog2(TLB_ENTRIES);
   localparam int FIW   = $clog2(FRAME_COUNT);
   localparam int SCW   = (TIW > FIW) ? TIW : FIW;
   localparam int FEXW  = (FIW > FRAME_OUT_W) ? FIW : FRAME_OUT_W;
   localparam int SEXW  = (TIW > SLOT_OUT_W) ? TIW : SLOT_OUT_W;
   localparam int TWW   = PAGE_W + FIW;
   localparam logic [SCW-1:0] TLB_LAST   = SCW'(TLB_ENTRIES - 1);
   localparam logic [SCW-1:0] FRAME_LAST = SCW'(FRAME_COUNT - 1);
   localparam logic [TIW-1:0] TPTR_LAST  = TIW'(TLB_ENTRIES - 1);
   localparam logic [FIW-1:0] FPTR_LAST  = FIW'(FRAME_COUNT - 1);

   // Sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_TLB  = 3'd1;
   localparam logic [2:0] S_FRM  = 3'd2;
   localparam logic [2:0] S_RD   = 3'd3;
   localparam logic [2:0] S_WB   = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic                  policy_ff, policy_in;
   logic [PAGE_W-1:0]     page_ff, page_in;
   logic [OFFSET_W-1:0]   offset_ff, offset_in;
   logic [SCW-1:0]        scan_ff, scan_in;
   logic                  pend_ff, pend_in;
   logic [SCW-1:0]        pidx_ff, pidx_in;
   logic [FIW-1:0]        frame_ff, frame_in;
   logic                  hit_ff, hit_in;
   logic                  fault_ff, fault_in;
   logic [TIW-1:0]        slot_ff, slot_in;
   logic [TIW-1:0]        tlb_ptr_ff, tlb_ptr_in;
   logic [FIW-1:0]        fifo_ptr_ff, fifo_ptr_in;
   logic [STAMP_BITS-1:0] stamp_cnt_ff, stamp_cnt_in;
   logic [TLB_ENTRIES-1:0] tlb_valid_ff;

   // TLB memory: {page, frame}
   logic [TWW-1:0]        tlb_mem [TLB_ENTRIES];
   logic [TWW-1:0]        tlb_rd_ff;
   logic                  tlb_rd_en;
   logic                  tlb_wr_en;
   logic [PAGE_W-1:0]     tlb_rd_page;
   logic [FIW-1:0]        tlb_rd_frame;
   logic                  tlb_match;

   // Frame table interface
   ft_ctl_type            ft_ctl;
   ft_sts_type            ft_sts;
   logic [FIW-1:0]        ft_rd_idx;
   logic [STAMP_BITS-1:0] ft_stamp;
   logic [FIW-1:0]        lru_idx;
   logic [FIW-1:0]        frame_sel;

   // Result register
   logic                  rsp_valid_ff;
   logic [PADDR_W-1:0]    rsp_paddr_ff;
   logic [FRAME_OUT_W-1:0] rsp_frame_ff;
   logic                  rsp_hit_ff;
   logic                  rsp_fault_ff;
   logic [SLOT_OUT_W-1:0] rsp_slot_ff;
   logic                  rsp_load;
   logic [FEXW-1:0]       frame_ext;
   logic [SEXW-1:0]       slot_ext;

   logic                  req_xfer;
   logic                  rsp_xfer;

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid & ~req_stall;
   assign rsp_xfer  = rsp_valid_ff & ~rsp_stall;
   assign csr_ready = 1'b1;

   assign tlb_rd_page  = tlb_rd_ff[TWW-1:FIW];
   assign tlb_rd_frame = tlb_rd_ff[FIW-1:0];
   assign tlb_match    = pend_ff && tlb_valid_ff[pidx_ff[TIW-1:0]] && (tlb_rd_page == page_ff);

   // Replaced frame: LRU pick on a fault under LRU, else the frame already chosen
   assign frame_sel = (fault_ff && (policy_ff == POLICY_LRU)) ? lru_idx : frame_ff;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      policy_in    = policy_ff;
      page_in      = page_ff;
      offset_in    = offset_ff;
      scan_in      = scan_ff;
      pend_in      = pend_ff;
      pidx_in      = pidx_ff;
      frame_in     = frame_ff;
      hit_in       = hit_ff;
      fault_in     = fault_ff;
      slot_in      = slot_ff;
      tlb_ptr_in   = tlb_ptr_ff;
      fifo_ptr_in  = fifo_ptr_ff;
      stamp_cnt_in = stamp_cnt_ff;
      tlb_rd_en    = 1'b0;
      tlb_wr_en    = 1'b0;
      ft_ctl       = '0;
      ft_rd_idx    = scan_ff[FIW-1:0];
      ft_stamp     = stamp_cnt_ff;
      rsp_load     = 1'b0;

      if (csr_valid && csr_ready) begin
         policy_in = csr_replacement_policy;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               page_in   = req_logical_address[ADDR_W-1:OFFSET_W];
               offset_in = req_logical_address[OFFSET_W-1:0];
               scan_in   = '0;
               pend_in   = 1'b0;
               hit_in    = 1'b0;
               fault_in  = 1'b0;
               state_in  = S_TLB;
            end
         end

         // Sweep the TLB; first valid match wins
         S_TLB: begin
            tlb_rd_en = 1'b1;
            pend_in   = 1'b1;
            pidx_in   = scan_ff;
            scan_in   = (scan_ff == TLB_LAST) ? scan_ff : scan_ff + SCW'(1);
            if (tlb_match) begin
               frame_in = tlb_rd_frame;
               hit_in   = 1'b1;
               pend_in  = 1'b0;
               state_in = S_RD;
            end else if (pend_ff && (pidx_ff == TLB_LAST)) begin
               scan_in  = '0;
               pend_in  = 1'b0;
               state_in = S_FRM;
            end
         end

         // Sweep the frame table; LRU minimum is tracked alongside
         S_FRM: begin
            ft_ctl.rd_en      = 1'b1;
            ft_ctl.scan_start = (scan_ff == '0);
            pend_in           = 1'b1;
            pidx_in           = scan_ff;
            scan_in           = (scan_ff == FRAME_LAST) ? scan_ff : scan_ff + SCW'(1);
            if (ft_sts.page_hit) begin
               frame_in = pidx_ff[FIW-1:0];
               pend_in  = 1'b0;
               state_in = S_RD;
            end else if (ft_sts.rd_done && (pidx_ff == FRAME_LAST)) begin
               fault_in = 1'b1;
               pend_in  = 1'b0;
               if (policy_ff == POLICY_FIFO) begin
                  frame_in    = fifo_ptr_ff;
                  fifo_ptr_in = (fifo_ptr_ff == FPTR_LAST) ? '0 : fifo_ptr_ff + FIW'(1);
               end
               state_in = S_RD;
            end
         end

         // Read the chosen frame entry for the merge
         S_RD: begin
            ft_ctl.rd_en = 1'b1;
            ft_rd_idx    = frame_sel;
            frame_in     = frame_sel;
            state_in     = S_WB;
         end

         // Write back frame entry and the TLB slot
         S_WB: begin
            ft_ctl.wr_en     = 1'b1;
            ft_ctl.set_page  = fault_ff;
            ft_ctl.set_stamp = (policy_ff == POLICY_LRU);
            if (policy_ff == POLICY_LRU) begin
               // a replacement stamps twice; only the second stamp survives
               ft_stamp     = fault_ff ? stamp_cnt_ff + STAMP_BITS'(1) : stamp_cnt_ff;
               stamp_cnt_in = fault_ff ? stamp_cnt_ff + STAMP_BITS'(2)
                                       : stamp_cnt_ff + STAMP_BITS'(1);
            end
            tlb_wr_en  = 1'b1;
            slot_in    = tlb_ptr_ff;
            tlb_ptr_in = (tlb_ptr_ff == TPTR_LAST) ? '0 : tlb_ptr_ff + TIW'(1);
            state_in   = S_OUT;
         end

         // Hand the result to the output register once it is free
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         policy_ff    <= POLICY_FIFO;
         pend_ff      <= 1'b0;
         tlb_ptr_ff   <= '0;
         fifo_ptr_ff  <= '0;
         stamp_cnt_ff <= '0;
         tlb_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         policy_ff    <= policy_in;
         pend_ff      <= pend_in;
         tlb_ptr_ff   <= tlb_ptr_in;
         fifo_ptr_ff  <= fifo_ptr_in;
         stamp_cnt_ff <= stamp_cnt_in;
         if (tlb_wr_en) begin
            tlb_valid_ff[tlb_ptr_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      page_ff   <= page_in;
      offset_ff <= offset_in;
      scan_ff   <= scan_in;
      pidx_ff   <= pidx_in;
      frame_ff  <= frame_in;
      hit_ff    <= hit_in;
      fault_ff  <= fault_in;
      slot_ff   <= slot_in;
   end

   // TLB memory port
   always_ff @(posedge clock) begin
      if (tlb_rd_en) begin
         tlb_rd_ff <= tlb_mem[scan_ff[TIW-1:0]];
      end
      if (tlb_wr_en) begin
         tlb_mem[tlb_ptr_ff] <= {page_ff, frame_ff};
      end
   end

   tlbpt_frame_table #(
      .FRAME_COUNT (FRAME_COUNT),
      .STAMP_BITS  (STAMP_BITS)
   ) u_frame_table (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ft_ctl),
      .rd_idx   (ft_rd_idx),
      .wr_idx   (frame_ff),
      .page     (page_ff),
      .stamp_in (ft_stamp),
      .sts      (ft_sts),
      .lru_idx  (lru_idx)
   );

   // Result register
   assign frame_ext = FEXW'(frame_ff);
   assign slot_ext  = SEXW'(slot_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_xfer) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_paddr_ff <= {frame_ext[FRAME_OUT_W-1:0], offset_ff};
         rsp_frame_ff <= frame_ext[FRAME_OUT_W-1:0];
         rsp_hit_ff   <= hit_ff;
         rsp_fault_ff <= fault_ff;
         rsp_slot_ff  <= slot_ext[SLOT_OUT_W-1:0];
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_physical_address = rsp_paddr_ff;
   assign rsp_frame_number     = rsp_frame_ff;
   assign rsp_tlb_hit          = rsp_hit_ff;
   assign rsp_page_fault       = rsp_fault_ff;
   assign rsp_tlb_slot         = rsp_slot_ff;

endmodule

`default_nettype wire

@@ design/tlbpt_checker.sv @@
// Port-level checker for the TLB page translator, bound to the top level.
`default_nettype none

module tlbpt_checker
   import tlbpt_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_stall,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire logic [PADDR_W-1:0]    rsp_physical_address,
   input  wire logic [FRAME_OUT_W-1:0] rsp_frame_number,
   input  wire logic                  rsp_tlb_hit,
   input  wire logic                  rsp_page_fault,
   input  wire logic [SLOT_OUT_W-1:0] rsp_tlb_slot
);

   // A stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_physical_address)
         && $stable(rsp_tlb_slot) && $stable(rsp_page_fault))
      else $error("stalled result changed");

   // A fault is never reported together with a TLB hit
   a_hit_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_tlb_hit && rsp_page_fault))
      else $error("tlb hit and page fault both set");

   // Physical address carries the frame in its upper bits
   a_paddr_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_physical_address[PADDR_W-1:OFFSET_W] == rsp_frame_number))
      else $error("physical address does not match frame");

   // One address in flight: after a transfer the request side stalls
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while busy");

endmodule

bind tlb_page_translator_fifo_lru tlbpt_checker u_tlbpt_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_physical_address (rsp_physical_address),
   .rsp_frame_number     (rsp_frame_number),
   .rsp_tlb_hit          (rsp_tlb_hit),
   .rsp_page_fault       (rsp_page_fault),
   .rsp_tlb_slot         (rsp_tlb_slot)
);

`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench for the TLB page translator: directed table, then random traffic.
module tb_top;
   import tlbpt_pkg::*;

   localparam int NTLB       = TLB_ENTRIES_DEF;
   localparam int NFRAME     = FRAME_COUNT_DEF;
   localparam int QUIET_MAX  = 5000;   // cycles with no transfer at all before giving up
   localparam int DRAIN_WAIT = 300;    // about two worst-case misses
   localparam int PHASE_LEN  = 128;

   // One translation as it leaves the block
   typedef struct packed {
      logic [PADDR_W-1:0]     phys_addr;
      logic [FRAME_OUT_W-1:0] frame;
      logic                   tlb_hit;
      logic                   fault;
      logic [SLOT_OUT_W-1:0]  slot;
   } translation_t;

   // One row of the directed table: a policy write or an address
   typedef struct packed {
      logic              is_policy;
      logic              policy_val;
      logic [ADDR_W-1:0] addr;
      logic              typed;
      translation_t      want;
   } step_t;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [ADDR_W-1:0] req_logical_address;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [PADDR_W-1:0] rsp_physical_address;
   logic [FRAME_OUT_W-1:0] rsp_frame_number;
   logic rsp_tlb_hit;
   logic rsp_page_fault;
   logic [SLOT_OUT_W-1:0] rsp_tlb_slot;
   logic csr_valid;
   logic csr_ready;
   logic csr_replacement_policy;

   // Translator state as the predictor sees it
   logic [PAGE_W-1:0]         tlb_tag [NTLB];
   logic                      tlb_live [NTLB];
   int                        tlb_pfn [NTLB];
   logic [PAGE_W-1:0]         owner_page [NFRAME];
   logic                      owner_live [NFRAME];
   logic [STAMP_BITS_DEF-1:0] last_use [NFRAME];
   logic [STAMP_BITS_DEF-1:0] use_clock;
   int                        fifo_next;
   int                        tlb_next;
   logic                      policy_reg;

   translation_t pending[$];

   int send_gap_pct = 0;
   int stall_pct    = 0;
   int quiet_cycles = 0;
   int mismatches   = 0;
   int items_sent   = 0;
   int policy_writes = 0;
   int n_checked    = 0;
   int n_tlb_hits   = 0;
   int n_table_hits = 0;
   int n_faults     = 0;

   // Directed rows; typed results follow from reset state and the rows before them
   step_t plan [22] = '{
      '{1'b0, POLICY_FIFO, 16'h0000, 1'b1, '{15'h0000, 7'd0, 1'b0, 1'b1, 4'd0}},
      '{1'b0, POLICY_FIFO, 16'h00FF, 1'b1, '{15'h00FF, 7'd0, 1'b1, 1'b0, 4'd1}},
      '{1'b0, POLICY_FIFO, 16'hFFFF, 1'b1, '{15'h01FF, 7'd1, 1'b0, 1'b1, 4'd2}},
      '{1'b0, POLICY_FIFO, 16'hFF00, 1'b1, '{15'h0100, 7'd1, 1'b1, 1'b0, 4'd3}},
      '{1'b0, POLICY_FIFO, 16'h8001, 1'b1, '{15'h0201, 7'd2, 1'b0, 1'b1, 4'd4}},
      '{1'b0, POLICY_FIFO, 16'h7FFE, 1'b1, '{15'h03FE, 7'd3, 1'b0, 1'b1, 4'd5}},
      '{1'b0, POLICY_FIFO, 16'h5555, 1'b1, '{15'h0455, 7'd4, 1'b0, 1'b1, 4'd6}},
      '{1'b0, POLICY_FIFO, 16'hAAAA, 1'b1, '{15'h05AA, 7'd5, 1'b0, 1'b1, 4'd7}},
      '{1'b1, POLICY_LRU,  16'h0000, 1'b0, '0},
      // all stamps zero: lowest index wins the tie
      '{1'b0, POLICY_FIFO, 16'h1234, 1'b1, '{15'h0034, 7'd0, 1'b0, 1'b1, 4'd8}},
      // stale TLB entry for page 0 still points at the reused frame
      '{1'b0, POLICY_FIFO, 16'h0033, 1'b1, '{15'h0033, 7'd0, 1'b1, 1'b0, 4'd9}},
      '{1'b0, POLICY_FIFO, 16'h4400, 1'b1, '{15'h0100, 7'd1, 1'b0, 1'b1, 4'd10}},
      '{1'b0, POLICY_FIFO, 16'hFF80, 1'b1, '{15'h0180, 7'd1, 1'b1, 1'b0, 4'd11}},
      '{1'b0, POLICY_FIFO, 16'h2101, 1'b0, '0},
      '{1'b0, POLICY_FIFO, 16'h2202, 1'b0, '0},
      '{1'b0, POLICY_FIFO, 16'h2303, 1'b0, '0},
      '{1'b0, POLICY_FIFO, 16'h2404, 1'b0, '0},
      '{1'b0, POLICY_FIFO, 16'h2505, 1'b0, '0},
      '{1'b1, POLICY_FIFO, 16'h0000, 1'b0, '0},
      '{1'b0, POLICY_FIFO, 16'h3C3C, 1'b0, '0},
      '{1'b1, POLICY_LRU,  16'h0000, 1'b0, '0},
      '{1'b0, POLICY_FIFO, 16'h0000, 1'b0, '0}
   };

   tlb_page_translator_fifo_lru u_top (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_logical_address    (req_logical_address),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_physical_address   (rsp_physical_address),
      .rsp_frame_number       (rsp_frame_number),
      .rsp_tlb_hit            (rsp_tlb_hit),
      .rsp_page_fault         (rsp_page_fault),
      .rsp_tlb_slot           (rsp_tlb_slot),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_replacement_policy (csr_replacement_policy)
   );

   always #5 clock = ~clock;

   // Receiver back-pressure
   always @(negedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
   end

   function automatic void touch_frame(input int f);
      last_use[f] = use_clock;
      use_clock   = use_clock + 1'b1;
   endfunction

   // Translate one address and update the predicted state
   function automatic translation_t translate_address(input logic [ADDR_W-1:0] addr);
      logic [PAGE_W-1:0]   page;
      logic [OFFSET_W-1:0] offs;
      int                  frame;
      int                  slot;
      int                  i;
      bit                  found;
      bit                  hit;
      bit                  fault;
      translation_t        r;
      page  = addr[ADDR_W-1:OFFSET_W];
      offs  = addr[OFFSET_W-1:0];
      frame = 0;
      found = 1'b0;
      hit   = 1'b0;
      fault = 1'b0;
      // TLB first, lowest index wins
      for (i = 0; i < NTLB; i++) begin
         if (!found && tlb_live[i] && tlb_tag[i] == page) begin
            frame = tlb_pfn[i];
            found = 1'b1;
            hit   = 1'b1;
         end
      end
      // then the inverted frame table
      for (i = 0; i < NFRAME; i++) begin
         if (!found && owner_live[i] && owner_page[i] == page) begin
            frame = i;
            found = 1'b1;
         end
      end
      // replace a frame
      if (!found) begin
         fault = 1'b1;
         if (policy_reg == POLICY_FIFO) begin
            frame     = fifo_next;
            fifo_next = (fifo_next + 1) % NFRAME;
         end else begin
            frame = 0;
            for (i = 1; i < NFRAME; i++) begin
               if (last_use[i] < last_use[frame]) frame = i;
            end
            touch_frame(frame);
         end
         owner_page[frame] = page;
         owner_live[frame] = 1'b1;
      end
      if (policy_reg == POLICY_LRU) touch_frame(frame);
      // round-robin TLB fill
      slot          = tlb_next;
      tlb_tag[slot] = page;
      tlb_pfn[slot] = frame;
      tlb_live[slot] = 1'b1;
      tlb_next      = (slot + 1) % NTLB;
      r.phys_addr = PADDR_W'(frame * 256 + int'(offs));
      r.frame     = FRAME_OUT_W'(frame);
      r.tlb_hit   = hit;
      r.fault     = fault;
      r.slot      = SLOT_OUT_W'(slot);
      return r;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // Present one address, hold it until the transfer, record what it should give
   task automatic send_address(input logic [ADDR_W-1:0] addr, input bit use_typed,
                               input translation_t typed_want);
      translation_t predicted;
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_logical_address <= addr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = translate_address(addr);
      pending.push_back(use_typed ? typed_want : predicted);
      items_sent++;
      @(negedge clock);
   endtask

   // Stop sending and wait for every outstanding result
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending.size() != 0) @(negedge clock);
   endtask

   task automatic write_policy(input logic pol);
      csr_valid              <= 1'b1;
      csr_replacement_policy <= pol;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      policy_reg = pol;
      policy_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Result checker and watchdog
   always @(posedge clock) begin : result_check
      translation_t want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual pa 0x%0h frame %0d",
                        $time, rsp_physical_address, rsp_frame_number);
               mismatches++;
            end else begin
               want = pending.pop_front();
               check_field("physical_address", want.phys_addr, rsp_physical_address);
               check_field("frame_number", want.frame, rsp_frame_number);
               check_field("tlb_hit", want.tlb_hit, rsp_tlb_hit);
               check_field("page_fault", want.fault, rsp_page_fault);
               check_field("tlb_slot", want.slot, rsp_tlb_slot);
               n_checked++;
               if (want.tlb_hit) n_tlb_hits++;
               else if (want.fault) n_faults++;
               else n_table_hits++;
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_MAX) begin
               $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                        $time, quiet_cycles, pending.size());
               $display("Verification failed");
               $finish;
            end
         end
      end
   end

   // Stimulus
   initial begin
      int          k;
      int          ph;
      int          n;
      int          left;
      int          mode;
      int          pool;
      int          base;
      logic [ADDR_W-1:0] addr;
      logic [PAGE_W-1:0] page_sel;
      reset                  = 1'b1;
      req_valid              = 1'b0;
      req_logical_address    = '0;
      csr_valid              = 1'b0;
      csr_replacement_policy = POLICY_FIFO;
      // predictor reset state
      foreach (tlb_live[i]) begin
         tlb_live[i] = 1'b0;
         tlb_tag[i]  = '0;
         tlb_pfn[i]  = 0;
      end
      foreach (owner_live[i]) begin
         owner_live[i] = 1'b0;
         owner_page[i] = '0;
         last_use[i]   = '0;
      end
      use_clock  = '0;
      fifo_next  = 0;
      tlb_next   = 0;
      policy_reg = POLICY_FIFO;
      left = 0;
      mode = 0;
      pool = 1;
      base = 0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table, back to back
      for (k = 0; k < $size(plan); k++) begin
         if (plan[k].is_policy) begin
            wait_drained();
            write_policy(plan[k].policy_val);
         end else begin
            send_address(plan[k].addr, plan[k].typed, plan[k].want);
         end
      end

      // random phases: each idle mix under both policies
      for (ph = 0; ph < 8; ph++) begin
         wait_drained();
         write_policy(((ph % 2) == 1) != (ph >= 4) ? POLICY_LRU : POLICY_FIFO);
         case (ph % 4)
            0: begin send_gap_pct = 0;  stall_pct = 0;  end
            1: begin send_gap_pct = 86; stall_pct = 0;  end
            2: begin send_gap_pct = 0;  stall_pct = 86; end
            default: begin send_gap_pct = 29; stall_pct = 29; end
         endcase
         for (n = 0; n < PHASE_LEN; n++) begin
            // bursts over a page working set: small sets hit the TLB, mid sets the
            // frame table, large sets force replacement; some fully random noise
            if (left == 0) begin
               left = $urandom_range(8, 40);
               k    = $urandom_range(0, 99);
               if (k < 20) begin mode = 0; pool = $urandom_range(1, 12); end
               else if (k < 55) begin mode = 1; pool = $urandom_range(17, 100); end
               else if (k < 85) begin mode = 2; pool = $urandom_range(129, 256); end
               else begin mode = 3; pool = 256; end
               base = $urandom_range(0, 255);
            end
            left--;
            if (mode == 3) begin
               addr = ADDR_W'($urandom);
            end else begin
               page_sel = PAGE_W'(base + $urandom_range(0, pool - 1));
               addr     = {page_sel, OFFSET_W'($urandom)};
            end
            send_address(addr, 1'b0, '0);
         end
      end

      // drain and let the block settle
      wait_drained();
      stall_pct = 0;
      repeat (DRAIN_WAIT) @(negedge clock);

      $display("Sent %0d addresses under FIFO and LRU (%0d policy writes) with four idle mixes.",
               items_sent, policy_writes);
      $display("Checked %0d results: %0d TLB hits, %0d frame table hits, %0d faults; %0d bad.",
               n_checked, n_tlb_hits, n_table_hits, n_faults, mismatches);
      if (mismatches == 0 && pending.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
design/tlbpt_pkg.sv
design/tlbpt_frame_table.sv
design/tlb_page_translator_fifo_lru.sv
design/tlbpt_checker.sv
sim/tb_top.sv
